>>> design/brb_pkg.sv
// Shared types, codes and defaults for the broadcast ring buffer.
// No dependencies; every other design file imports this package.
`default_nettype none

package brb_pkg;

  // Parameter defaults
  localparam int DEPTH_DEF        = 16;
  localparam int MAX_CONS_DEF     = 8;
  localparam int DATA_WIDTH_DEF   = 32;

  // Register reset values (clamped to the parameters where used)
  localparam int SLOTS_RESET      = 16;
  localparam int CONS_RESET       = 4;

  // Configuration port
  localparam int CFG_ADDR_W       = 2;
  localparam int CFG_DATA_W       = 5;
  localparam logic [CFG_ADDR_W-1:0] REG_SLOTS     = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_CONSUMERS = 2'd1;

  // Producer waiting count
  localparam int PROD_W           = 4;
  localparam logic [PROD_W-1:0] PROD_WAIT_MAX = 4'd15;

  // Request commands
  localparam logic CMD_WRITE      = 1'b0;
  localparam logic CMD_READ       = 1'b1;

  // Result status codes
  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_FULL     = 2'd1;
  localparam logic [1:0] STS_EMPTY    = 2'd2;
  localparam logic [1:0] STS_INACTIVE = 2'd3;

  // Wake hint codes
  localparam logic [1:0] WAKE_NONE     = 2'd0;
  localparam logic [1:0] WAKE_CONSUMER = 2'd1;
  localparam logic [1:0] WAKE_PRODUCER = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic clr_step;   // clear one entry of the pending and pointer memories
    logic accept;     // latch request, read pending at write slot and read pointer
    logic fetch;      // read item and pending count at the read pointer
    logic commit;     // update state and load the result register
  } brb_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;   // clear pass is at its last entry
  } brb_stat_t;

endpackage

`default_nettype wire

>>> design/brb_ifs.sv
// Channel interfaces of the broadcast ring buffer: request, result, configuration.
// Depends on brb_pkg for widths and defaults.
`default_nettype none

interface brb_req_if
  import brb_pkg::*;
#(
  parameter int DATA_WIDTH    = DATA_WIDTH_DEF,
  parameter int MAX_CONSUMERS = MAX_CONS_DEF
);
  localparam int ID_W = (MAX_CONSUMERS > 1) ? $clog2(MAX_CONSUMERS) : 1;

  logic                  valid;
  logic                  ready;
  logic                  cmd;
  logic [ID_W-1:0]       consumer_id;
  logic [DATA_WIDTH-1:0] data_in;

  modport source (output valid, cmd, consumer_id, data_in, input ready);
  modport sink   (input valid, cmd, consumer_id, data_in, output ready);
endinterface

interface brb_rsp_if
  import brb_pkg::*;
#(
  parameter int DATA_WIDTH    = DATA_WIDTH_DEF,
  parameter int DEPTH         = DEPTH_DEF,
  parameter int MAX_CONSUMERS = MAX_CONS_DEF
);
  localparam int ID_W  = (MAX_CONSUMERS > 1) ? $clog2(MAX_CONSUMERS) : 1;
  localparam int PTR_W = $clog2(DEPTH);

  logic                  valid;
  logic                  ready;
  logic [1:0]            status;
  logic [DATA_WIDTH-1:0] read_data;
  logic [PTR_W-1:0]      slot_used;
  logic [1:0]            wake_kind;
  logic [ID_W-1:0]       wake_consumer;

  modport source (output valid, status, read_data, slot_used, wake_kind, wake_consumer,
                  input ready);
  modport sink   (input valid, status, read_data, slot_used, wake_kind, wake_consumer,
                  output ready);
endinterface

interface brb_cfg_if
  import brb_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] index;
  logic [CFG_DATA_W-1:0] value;

  modport source (output valid, index, value, input ready);
  modport sink   (input valid, index, value, output ready);
endinterface

`default_nettype wire

>>> design/brb_ctrl.sv
// Sequencer of the broadcast ring buffer: clear pass, accept, fetch, commit,
// and the valid flag of the result register. Depends on brb_pkg.
`default_nettype none

module brb_ctrl
  import brb_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      req_valid,
  output logic           req_ready,
  output logic           rsp_valid,
  input  wire logic      rsp_ready,
  output brb_cmd_t       ctl,
  input  wire brb_stat_t stat
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_FETCH = 2'd2;
  localparam logic [1:0] ST_EXEC  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       rsp_valid_next;
  logic       out_free;

  // Result register can take a new result when empty or being drained
  assign out_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == ST_IDLE);

  // Issue datapath commands
  always_comb begin
    ctl.clr_step = (state == ST_CLEAR);
    ctl.accept   = (state == ST_IDLE) && req_valid;
    ctl.fetch    = (state == ST_FETCH);
    ctl.commit   = (state == ST_EXEC) && out_free;
  end

  // Advance the sequence
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (stat.clr_last) state_next = ST_IDLE;
      ST_IDLE:  if (req_valid) state_next = ST_FETCH;
      ST_FETCH: state_next = ST_EXEC;
      ST_EXEC:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  // Set the result valid on commit, drop it when taken
  always_comb begin
    if (ctl.commit) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end else begin
      rsp_valid_next = rsp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // A new result appears only out of the commit state
  a_rsp_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == ST_EXEC)
    else $error("result valid rose outside commit");

  // An accepted request always goes on to the fetch step
  a_accept_fetch: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> state == ST_FETCH)
    else $error("accepted request did not reach fetch");

  // Commit waits while the previous result is still held
  a_exec_hold: assert property (@(posedge clk) disable iff (rst)
    state == ST_EXEC && rsp_valid && !rsp_ready |=> state == ST_EXEC && !ctl.accept)
    else $error("commit did not wait for the result register");

endmodule

`default_nettype wire

>>> design/brb_dp.sv
// Datapath of the broadcast ring buffer: configuration registers, item and
// pending memories, read pointer memory, per-consumer counters, wake pick and
// result register. Depends on brb_pkg; driven by brb_ctrl commands.
`default_nettype none

module brb_dp
  import brb_pkg::*;
#(
  parameter int DEPTH         = DEPTH_DEF,
  parameter int MAX_CONSUMERS = MAX_CONS_DEF,
  parameter int DATA_WIDTH    = DATA_WIDTH_DEF,
  localparam int PTR_W        = $clog2(DEPTH),
  localparam int ID_W         = (MAX_CONSUMERS > 1) ? $clog2(MAX_CONSUMERS) : 1
)(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire brb_cmd_t              ctl,
  output brb_stat_t                  stat,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_value,
  input  wire logic                  req_cmd,
  input  wire logic [ID_W-1:0]       req_consumer_id,
  input  wire logic [DATA_WIDTH-1:0] req_data_in,
  output logic [1:0]                 rsp_status,
  output logic [DATA_WIDTH-1:0]      rsp_read_data,
  output logic [PTR_W-1:0]           rsp_slot_used,
  output logic [1:0]                 rsp_wake_kind,
  output logic [ID_W-1:0]            rsp_wake_consumer
);

  localparam int SLOTS_W    = $clog2(DEPTH + 1);
  localparam int CONS_W     = $clog2(MAX_CONSUMERS + 1);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int CLR_N      = (DEPTH > MAX_CONSUMERS) ? DEPTH : MAX_CONSUMERS;
  localparam int CLR_W      = $clog2(CLR_N);
  localparam int SLOTS_INIT = (SLOTS_RESET > DEPTH) ? DEPTH : SLOTS_RESET;
  localparam int CONS_INIT  = (CONS_RESET > MAX_CONSUMERS) ? MAX_CONSUMERS : CONS_RESET;

  // Configuration
  logic [SLOTS_W-1:0] slots_in_use;
  logic [CONS_W-1:0]  consumers_in_use;

  // Memories
  logic [DATA_WIDTH-1:0] item_mem [DEPTH];
  logic [CONS_W-1:0]     pend_mem [DEPTH];
  logic [PTR_W-1:0]      rp_mem   [MAX_CONSUMERS];

  // Control state
  logic [PTR_W-1:0]  write_pointer;
  logic [CNT_W-1:0]  unread_counts [MAX_CONSUMERS];
  logic [MAX_CONSUMERS-1:0] consumer_waiting;
  logic [PROD_W-1:0] producers_waiting;
  logic [CLR_W-1:0]  clr_cnt;

  // Request latch and registered memory reads
  logic                  cmd_q;
  logic [ID_W-1:0]       id_q;
  logic [DATA_WIDTH-1:0] data_q;
  logic [CONS_W-1:0]     pend_wp_q;
  logic [CONS_W-1:0]     pend_rp_q;
  logic [PTR_W-1:0]      rp_q;
  logic [DATA_WIDTH-1:0] item_q;

  // Commit values
  logic [PTR_W-1:0]  write_pointer_next;
  logic [CNT_W-1:0]  unread_counts_next [MAX_CONSUMERS];
  logic [MAX_CONSUMERS-1:0] consumer_waiting_next;
  logic [PROD_W-1:0] producers_waiting_next;
  logic              item_we;
  logic              pend_we;
  logic [PTR_W-1:0]  pend_waddr;
  logic [CONS_W-1:0] pend_wdata;
  logic              rp_we;
  logic [PTR_W-1:0]  rp_wdata;
  logic [CONS_W-1:0] pend_wp_after;
  logic              wake_en;
  logic              prod_cond;
  logic [MAX_CONSUMERS-1:0] wake_flags;
  logic [ID_W-1:0]   wake_pick;
  logic [1:0]        res_status;
  logic [DATA_WIDTH-1:0] res_data;
  logic [PTR_W-1:0]  res_slot;
  logic [1:0]        res_wkind;
  logic [ID_W-1:0]   res_wcons;

  // Step a pointer, wrapping at the ring size in use
  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                               input logic [SLOTS_W-1:0] lim);
    logic [PTR_W:0] n;
    n = {1'b0, p} + {{PTR_W{1'b0}}, 1'b1};
    if (int'(n) >= int'(lim) || int'(n) >= DEPTH) begin
      return '0;
    end
    return n[PTR_W-1:0];
  endfunction

  assign stat.clr_last = (clr_cnt == CLR_W'(CLR_N - 1));

  // Configuration writes, clamped into range
  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use     <= SLOTS_W'(SLOTS_INIT);
      consumers_in_use <= CONS_W'(CONS_INIT);
    end else if (cfg_we) begin
      if (cfg_index == REG_SLOTS) begin
        if (cfg_value == '0) begin
          slots_in_use <= SLOTS_W'(1);
        end else if (int'(cfg_value) > DEPTH) begin
          slots_in_use <= SLOTS_W'(DEPTH);
        end else begin
          slots_in_use <= SLOTS_W'(cfg_value);
        end
      end else if (cfg_index == REG_CONSUMERS) begin
        if (cfg_value[3:0] == 4'd0) begin
          consumers_in_use <= CONS_W'(1);
        end else if (int'(cfg_value[3:0]) > MAX_CONSUMERS) begin
          consumers_in_use <= CONS_W'(MAX_CONSUMERS);
        end else begin
          consumers_in_use <= CONS_W'(cfg_value[3:0]);
        end
      end
    end
  end

  // Latch the request
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      cmd_q  <= req_cmd;
      id_q   <= req_consumer_id;
      data_q <= req_data_in;
    end
  end

  // Item memory: write at commit, read at the read pointer on fetch
  always_ff @(posedge clk) begin
    if (item_we) begin
      item_mem[write_pointer] <= data_q;
    end
    if (ctl.fetch) begin
      item_q <= item_mem[rp_q];
    end
  end

  // Pending memory: cleared after reset, written at commit, read at both pointers
  always_ff @(posedge clk) begin
    if (ctl.clr_step && int'(clr_cnt) < DEPTH) begin
      pend_mem[clr_cnt[PTR_W-1:0]] <= '0;
    end else if (pend_we) begin
      pend_mem[pend_waddr] <= pend_wdata;
    end
    if (ctl.accept) begin
      pend_wp_q <= pend_mem[write_pointer];
    end
    if (ctl.fetch) begin
      pend_rp_q <= pend_mem[rp_q];
    end
  end

  // Read pointer memory: cleared after reset, read by consumer on accept
  always_ff @(posedge clk) begin
    if (ctl.clr_step && int'(clr_cnt) < MAX_CONSUMERS) begin
      rp_mem[clr_cnt[ID_W-1:0]] <= '0;
    end else if (rp_we) begin
      rp_mem[id_q] <= rp_wdata;
    end
    if (ctl.accept) begin
      rp_q <= rp_mem[req_consumer_id];
    end
  end

  // Work out the access, the new state and the wake hint
  always_comb begin
    write_pointer_next     = write_pointer;
    unread_counts_next     = unread_counts;
    consumer_waiting_next  = consumer_waiting;
    producers_waiting_next = producers_waiting;
    item_we       = 1'b0;
    pend_we       = 1'b0;
    pend_waddr    = write_pointer;
    pend_wdata    = '0;
    rp_we         = 1'b0;
    rp_wdata      = '0;
    pend_wp_after = pend_wp_q;
    wake_en       = 1'b0;
    prod_cond     = 1'b0;
    res_status    = STS_OK;
    res_data      = '0;
    res_slot      = '0;
    if (cmd_q == CMD_WRITE) begin
      if (pend_wp_q != '0) begin
        res_status = STS_FULL;
        if (producers_waiting != PROD_WAIT_MAX) begin
          producers_waiting_next = producers_waiting + PROD_W'(1);
        end
      end else begin
        if (producers_waiting != '0) begin
          producers_waiting_next = producers_waiting - PROD_W'(1);
        end
        item_we    = ctl.commit;
        pend_we    = ctl.commit;
        pend_wdata = consumers_in_use;
        for (int i = 0; i < MAX_CONSUMERS; i++) begin
          if (i < int'(consumers_in_use) && int'(unread_counts[i]) < DEPTH) begin
            unread_counts_next[i] = unread_counts[i] + CNT_W'(1);
          end
        end
        write_pointer_next = advance(write_pointer, slots_in_use);
        res_slot  = write_pointer;
        wake_en   = 1'b1;
        prod_cond = (producers_waiting_next != '0);
      end
    end else if (int'(id_q) >= int'(consumers_in_use)) begin
      res_status = STS_INACTIVE;
    end else if (unread_counts[id_q] == '0) begin
      res_status = STS_EMPTY;
      consumer_waiting_next[id_q] = 1'b1;
    end else begin
      consumer_waiting_next[id_q] = 1'b0;
      res_data   = item_q;
      pend_we    = ctl.commit;
      pend_waddr = rp_q;
      pend_wdata = (pend_rp_q != '0) ? pend_rp_q - CONS_W'(1) : '0;
      unread_counts_next[id_q] = unread_counts[id_q] - CNT_W'(1);
      rp_we      = ctl.commit;
      rp_wdata   = advance(rp_q, slots_in_use);
      res_slot   = rp_q;
      pend_wp_after = (rp_q == write_pointer) ? pend_wdata : pend_wp_q;
      wake_en    = 1'b1;
      prod_cond  = (pend_wp_after == '0) && (producers_waiting != '0);
    end

    // Lowest active waiting consumer that has data
    for (int i = 0; i < MAX_CONSUMERS; i++) begin
      wake_flags[i] = (i < int'(consumers_in_use)) && consumer_waiting_next[i] &&
                      (unread_counts_next[i] != '0);
    end
    wake_pick = '0;
    for (int i = MAX_CONSUMERS - 1; i >= 0; i--) begin
      if (wake_flags[i]) wake_pick = ID_W'(i);
    end

    res_wkind = WAKE_NONE;
    res_wcons = '0;
    if (wake_en) begin
      if (wake_flags != '0) begin
        res_wkind = WAKE_CONSUMER;
        res_wcons = wake_pick;
      end else if (prod_cond) begin
        res_wkind = WAKE_PRODUCER;
      end
    end
  end

  // Commit control state; step the clear counter
  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer     <= '0;
      consumer_waiting  <= '0;
      producers_waiting <= '0;
      clr_cnt           <= '0;
      for (int i = 0; i < MAX_CONSUMERS; i++) begin
        unread_counts[i] <= '0;
      end
    end else begin
      if (ctl.clr_step && !stat.clr_last) begin
        clr_cnt <= clr_cnt + CLR_W'(1);
      end
      if (ctl.commit) begin
        write_pointer     <= write_pointer_next;
        unread_counts     <= unread_counts_next;
        consumer_waiting  <= consumer_waiting_next;
        producers_waiting <= producers_waiting_next;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      rsp_status        <= res_status;
      rsp_read_data     <= res_data;
      rsp_slot_used     <= res_slot;
      rsp_wake_kind     <= res_wkind;
      rsp_wake_consumer <= res_wcons;
    end
  end

  // The write pointer always lands inside the ring
  a_wp_range: assert property (@(posedge clk) disable iff (rst)
    int'(write_pointer) < DEPTH && int'(write_pointer) < int'(slots_in_use) + DEPTH)
    else $error("write pointer beyond ring");

  // Clamped configuration stays in its legal range
  a_cfg_range: assert property (@(posedge clk) disable iff (rst)
    slots_in_use != '0 && int'(slots_in_use) <= DEPTH &&
    consumers_in_use != '0 && int'(consumers_in_use) <= MAX_CONSUMERS)
    else $error("configuration register out of range");

  // A refused write leaves the ring untouched
  a_full_no_store: assert property (@(posedge clk) disable iff (rst)
    ctl.commit && cmd_q == CMD_WRITE && pend_wp_q != '0 |=>
    $stable(write_pointer))
    else $error("refused write moved the write pointer");

endmodule

`default_nettype wire

>>> design/broadcast_ring_buffer.sv
// Top level of the broadcast ring buffer: joins brb_ctrl and brb_dp to the
// request, result and configuration channels. Depends on brb_pkg and brb_ifs.
//
//   channel  modport  moves
//   -------  -------  ------------------------------------------------------
//   req      sink     cmd, consumer_id, data_in: one access per transaction
//   rsp      source   status, read_data, slot_used, wake_kind, wake_consumer
//   cfg      sink     index, value: register write, always ready
//
// Each request goes through accept, fetch and commit, as set by two
// dependent registered memory reads: the consumer's read pointer, then the
// item and pending count at that slot.
// After reset a clearing pass over max(DEPTH, MAX_CONSUMERS) entries zeroes the
// pending and read pointer memories; no request is accepted meanwhile.
// The result register lets the next request be accepted while a result waits;
// commit holds while that register is full and not being taken.
`default_nettype none

module broadcast_ring_buffer
  import brb_pkg::*;
#(
  parameter int DEPTH         = DEPTH_DEF,
  parameter int MAX_CONSUMERS = MAX_CONS_DEF,
  parameter int DATA_WIDTH    = DATA_WIDTH_DEF
)(
  input  wire logic clk,
  input  wire logic rst,
  brb_req_if.sink   req,
  brb_rsp_if.source rsp,
  brb_cfg_if.sink   cfg
);

  brb_cmd_t  ctl;
  brb_stat_t stat;

  // Configuration writes are taken in any cycle
  assign cfg.ready = 1'b1;

  brb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .ctl       (ctl),
    .stat      (stat)
  );

  brb_dp #(
    .DEPTH         (DEPTH),
    .MAX_CONSUMERS (MAX_CONSUMERS),
    .DATA_WIDTH    (DATA_WIDTH)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .ctl               (ctl),
    .stat              (stat),
    .cfg_we            (cfg.valid),
    .cfg_index         (cfg.index),
    .cfg_value         (cfg.value),
    .req_cmd           (req.cmd),
    .req_consumer_id   (req.consumer_id),
    .req_data_in       (req.data_in),
    .rsp_status        (rsp.status),
    .rsp_read_data     (rsp.read_data),
    .rsp_slot_used     (rsp.slot_used),
    .rsp_wake_kind     (rsp.wake_kind),
    .rsp_wake_consumer (rsp.wake_consumer)
  );

endmodule

`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for broadcast_ring_buffer: directed and random accesses,
// predicted by an in-bench ring scoreboard. Depends on brb_pkg, brb_ifs, the RTL.

import brb_pkg::*;

localparam int ID_W  = $clog2(MAX_CONS_DEF);
localparam int PTR_W = $clog2(DEPTH_DEF);

typedef struct packed {
  logic                      cmd;
  logic [ID_W-1:0]           consumer_id;
  logic [DATA_WIDTH_DEF-1:0] data;
} access_t;

typedef struct packed {
  logic [1:0]                status;
  logic [DATA_WIDTH_DEF-1:0] read_data;
  logic [PTR_W-1:0]          slot;
  logic [1:0]                wake_kind;
  logic [ID_W-1:0]           wake_consumer;
} outcome_t;

class ring_scoreboard;
  int                        slot_count;
  int                        consumer_count;
  logic [DATA_WIDTH_DEF-1:0] items [DEPTH_DEF];
  bit                        written [DEPTH_DEF];
  logic [3:0]                pending [DEPTH_DEF];
  logic [PTR_W-1:0]          wr_ptr;
  logic [PTR_W-1:0]          rd_ptr [MAX_CONS_DEF];
  logic [4:0]                unread [MAX_CONS_DEF];
  bit                        waiting [MAX_CONS_DEF];
  logic [PROD_W-1:0]         prod_wait;
  outcome_t                  due_outcomes [$];
  int unsigned               mismatches;

  function new();
    slot_count     = SLOTS_RESET;
    consumer_count = CONS_RESET;
    foreach (items[i]) begin
      items[i]   = '0;
      written[i] = 1'b0;
      pending[i] = '0;
    end
    foreach (rd_ptr[i]) begin
      rd_ptr[i]  = '0;
      unread[i]  = '0;
      waiting[i] = 1'b0;
    end
    wr_ptr     = '0;
    prod_wait  = '0;
    mismatches = 0;
  endfunction

  // Wrap a pointer once its increment reaches the ring size
  function logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
    int n;
    n = int'(p) + 1;
    return (n >= slot_count) ? '0 : PTR_W'(n);
  endfunction

  // Lowest active waiting consumer that has something to read, or -1
  function int first_woken_consumer();
    for (int i = 0; i < consumer_count; i++)
      if (waiting[i] && unread[i] != 0) return i;
    return -1;
  endfunction

  // Clamp and hold a register value as the block does
  function void apply_register(input logic [CFG_ADDR_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] val);
    int v;
    if (idx == REG_SLOTS) begin
      v = int'(val);
      if (v < 1) v = 1;
      if (v > DEPTH_DEF) v = DEPTH_DEF;
      slot_count = v;
    end else if (idx == REG_CONSUMERS) begin
      v = int'(val[3:0]);
      if (v < 1) v = 1;
      if (v > MAX_CONS_DEF) v = MAX_CONS_DEF;
      consumer_count = v;
    end
  endfunction

  // True when a read by this consumer would hit a slot never written
  function bit reads_unwritten(input logic [ID_W-1:0] id);
    return int'(id) < consumer_count && unread[id] != 0 && !written[rd_ptr[id]];
  endfunction

  // Advance the ring state by one accepted access and queue its outcome
  function void log_access(input access_t a);
    outcome_t         e;
    logic [PTR_W-1:0] s;
    int               w;
    e = '0;
    if (a.cmd == CMD_WRITE) begin
      s = wr_ptr;
      if (pending[s] != 0) begin
        e.status = STS_FULL;
        if (prod_wait != PROD_WAIT_MAX) prod_wait++;
      end else begin
        if (prod_wait != 0) prod_wait--;
        items[s]   = a.data;
        written[s] = 1'b1;
        pending[s] = 4'(consumer_count);
        for (int i = 0; i < consumer_count; i++)
          if (unread[i] < DEPTH_DEF) unread[i]++;
        wr_ptr = advance(s);
        e.slot = s;
        w = first_woken_consumer();
        if (w >= 0) begin
          e.wake_kind     = WAKE_CONSUMER;
          e.wake_consumer = ID_W'(w);
        end else if (prod_wait != 0) begin
          e.wake_kind = WAKE_PRODUCER;
        end
      end
    end else if (int'(a.consumer_id) >= consumer_count) begin
      e.status = STS_INACTIVE;
    end else if (unread[a.consumer_id] == 0) begin
      e.status = STS_EMPTY;
      waiting[a.consumer_id] = 1'b1;
    end else begin
      s = rd_ptr[a.consumer_id];
      waiting[a.consumer_id] = 1'b0;
      e.read_data = items[s];
      if (pending[s] != 0) pending[s]--;
      unread[a.consumer_id]--;
      rd_ptr[a.consumer_id] = advance(s);
      e.slot = s;
      w = first_woken_consumer();
      if (w >= 0) begin
        e.wake_kind     = WAKE_CONSUMER;
        e.wake_consumer = ID_W'(w);
      end else if (pending[wr_ptr] == 0 && prod_wait != 0) begin
        e.wake_kind = WAKE_PRODUCER;
      end
    end
    due_outcomes.push_back(e);
  endfunction

  function int outstanding();
    return due_outcomes.size();
  endfunction

  // Compare one received result against the oldest expectation
  function void match_outcome(input outcome_t got);
    outcome_t e;
    if (due_outcomes.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected result status %0d data %h slot %0d wake %0d/%0d",
                 $realtime, got.status, got.read_data, got.slot, got.wake_kind,
                 got.wake_consumer);
      return;
    end
    e = due_outcomes.pop_front();
    if (got.status != e.status || got.read_data != e.read_data || got.slot != e.slot ||
        got.wake_kind != e.wake_kind || got.wake_consumer != e.wake_consumer) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: result mismatch", $realtime);
        $display("  expected status %0d data %h slot %0d wake %0d/%0d",
                 e.status, e.read_data, e.slot, e.wake_kind, e.wake_consumer);
        $display("  actual   status %0d data %h slot %0d wake %0d/%0d",
                 got.status, got.read_data, got.slot, got.wake_kind, got.wake_consumer);
      end
    end
  endfunction
endclass

module tb_top;

  localparam int          SETTLE_CYCLES = 8;
  localparam int          CYCLE_LIMIT   = 200_000;
  localparam int unsigned RANDOM_ITEMS  = 720;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_HI = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  int unsigned req_gap_max   = 8;
  int unsigned rsp_stall_max = 8;
  int unsigned cycle_count   = 0;

  ring_scoreboard sb = new();

  brb_req_if req_ch ();
  brb_rsp_if rsp_ch ();
  brb_cfg_if cfg_ch ();

  broadcast_ring_buffer dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Capture every result transaction
  always @(posedge clk) begin : capture
    outcome_t got;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got.status        = rsp_ch.status;
      got.read_data     = rsp_ch.read_data;
      got.slot          = rsp_ch.slot_used;
      got.wake_kind     = rsp_ch.wake_kind;
      got.wake_consumer = rsp_ch.wake_consumer;
      sb.match_outcome(got);
    end
  end

  // Stall the result side a random number of cycles before each transaction
  initial begin : result_sink
    int unsigned stall;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = $urandom_range(0, rsp_stall_max);
      if (stall != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
    end
  end

  function automatic access_t mk(input logic cmd, input int id, input logic [31:0] data);
    access_t a;
    a.cmd         = cmd;
    a.consumer_id = ID_W'(id);
    a.data        = data;
    return a;
  endfunction

  // Accesses mostly by active consumers, a few by any id, writes at the given share
  function automatic access_t random_access(input int unsigned write_pct);
    access_t a;
    a.cmd = ($urandom_range(0, 99) < write_pct) ? CMD_WRITE : CMD_READ;
    if ($urandom_range(0, 9) == 0)
      a.consumer_id = ID_W'($urandom_range(0, MAX_CONS_DEF - 1));
    else
      a.consumer_id = ID_W'($urandom_range(0, sb.consumer_count - 1));
    a.data = $urandom;
    return a;
  endfunction

  // Drive one access after a random gap and hold it until accepted
  task automatic send_access(input access_t a);
    int unsigned gap;
    // steer a read of a never-written slot into a write
    if (a.cmd == CMD_READ && sb.reads_unwritten(a.consumer_id)) a.cmd = CMD_WRITE;
    gap = $urandom_range(0, req_gap_max);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.cmd         <= a.cmd;
    req_ch.consumer_id <= a.consumer_id;
    req_ch.data_in     <= a.data;
    req_ch.valid       <= 1'b1;
    do @(posedge clk); while (!req_ch.ready);
    sb.log_access(a);
  endtask

  // Leave cfg valid high; the caller drops it after the last write
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_ch.index <= idx;
    cfg_ch.value <= val;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.apply_register(idx, val);
  endtask

  // Hold requests until every expected result is back, then let the block settle
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned random_sent;
    int unsigned phase_len;
    int unsigned write_pct;
    logic [CFG_DATA_W-1:0] slots_val;
    logic [CFG_DATA_W-1:0] cons_val;

    req_ch.valid       <= 1'b0;
    req_ch.cmd         <= CMD_WRITE;
    req_ch.consumer_id <= '0;
    req_ch.data_in     <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= REG_SLOTS;
    cfg_ch.value       <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Empty read by an active consumer, reads by inactive ids
    send_access(mk(CMD_READ, 0, 32'h0));
    send_access(mk(CMD_READ, 7, $urandom));
    send_access(mk(CMD_READ, 4, $urandom));
    drain_results();

    // One consumer: fill fifteen slots with data extremes, first write wakes consumer 0
    write_reg(REG_CONSUMERS, 5'd1);
    cfg_ch.valid <= 1'b0;
    send_access(mk(CMD_WRITE, $urandom, 32'h7FFF_FFFF));
    send_access(mk(CMD_WRITE, $urandom, 32'h8000_0000));
    send_access(mk(CMD_WRITE, $urandom, 32'hFFFF_FFFF));
    send_access(mk(CMD_WRITE, $urandom, 32'h0000_0000));
    repeat (11) send_access(mk(CMD_WRITE, $urandom, $urandom));
    drain_results();

    // Two consumers: unread count hits its ceiling, then full write and producer wake
    write_reg(REG_CONSUMERS, 5'd2);
    cfg_ch.valid <= 1'b0;
    send_access(mk(CMD_WRITE, $urandom, $urandom));
    send_access(mk(CMD_READ, 1, $urandom));
    send_access(mk(CMD_WRITE, $urandom, $urandom));
    send_access(mk(CMD_WRITE, $urandom, $urandom));
    send_access(mk(CMD_READ, 0, $urandom));
    send_access(mk(CMD_READ, 1, $urandom));
    send_access(mk(CMD_WRITE, $urandom, $urandom));
    drain_results();

    // Single slot, all consumers: pointers beyond the ring wrap
    write_reg(REG_SLOTS, 5'd1);
    write_reg(REG_CONSUMERS, 5'd8);
    cfg_ch.valid <= 1'b0;
    send_access(mk(CMD_WRITE, $urandom, $urandom));
    send_access(mk(CMD_READ, 7, $urandom));
    send_access(mk(CMD_READ, 0, $urandom));
    send_access(mk(CMD_READ, 0, $urandom));
    send_access(mk(CMD_WRITE, $urandom, $urandom));
    drain_results();

    // Random phases, each under a fresh ring size and consumer count
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 5))
        0:       slots_val = 5'd1;
        1:       slots_val = 5'd16;
        2:       slots_val = 5'd0;
        3:       slots_val = CFG_DATA_W'($urandom_range(17, 31));
        default: slots_val = CFG_DATA_W'($urandom_range(1, 16));
      endcase
      case ($urandom_range(0, 5))
        0:       cons_val = 5'd1;
        1:       cons_val = 5'd8;
        2:       cons_val = CFG_DATA_W'($urandom_range(0, 31));
        default: cons_val = CFG_DATA_W'($urandom_range(1, 8));
      endcase
      write_reg(REG_SLOTS, slots_val);
      write_reg(REG_CONSUMERS, cons_val);
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO,
                  CFG_DATA_W'($urandom));
      cfg_ch.valid <= 1'b0;

      req_gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 8;
      rsp_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
      write_pct     = $urandom_range(15, 70);
      phase_len     = $urandom_range(30, 70);
      repeat (phase_len) send_access(random_access(write_pct));
      random_sent += phase_len;
      drain_results();
    end

    if (sb.mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
